// File: rtl/core/obb_pkg.sv
package obb_pkg;

  // default coordinate width, signed Q8.8
  localparam int COORD_WIDTH_DEF = 16;

  // edge vectors per box pair, also the number of test axes
  localparam int NUM_AXES = 4;

  // edges from input transfer to the earliest result transfer, no stalls
  localparam int LATENCY = 5;

endpackage

// File: rtl/core/obb_overlap_separating_axis.sv
// channel  ports                                      direction  accepted when
// -------  -----------------------------------------  ---------  -------------------------
// input    in_valid, in_ready, in_a_*, in_b_*          in         in_valid && in_ready
// result   out_valid, out_ready, out_overlap          out        out_valid && out_ready
//
// one box pair per cycle sustained while out_ready holds, set by the five-stage
// pipeline: center diff, products, dot sums with magnitude, axis sums, compare
// into the result register. out_valid rises when the pair reaches the result
// register, and without back-pressure the result transfers while it is first offered.
// rst_n is synchronous and clears every stage valid bit; payload registers hold junk.
// each stage moves when it is empty or the stage after it moves, so bubbles are
// squeezed out and a stalled result register still lets earlier stages fill.
module obb_overlap_separating_axis
  import obb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_u_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_u_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_v_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_v_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_cx,
  input  logic signed [COORD_WIDTH-1:0] in_a_cy,
  input  logic signed [COORD_WIDTH-1:0] in_b_u_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_u_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_v_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_v_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_cx,
  input  logic signed [COORD_WIDTH-1:0] in_b_cy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W;      // edge by edge product
  localparam int CW = 2 * W + 1;  // center diff by edge product
  localparam int SW = 2 * W + 2;  // axis sum and doubled center term

  // stage valid bits and per-stage move enables
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;

  assign en_out   = !out_valid_r || out_ready;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // stage 1: edge vectors and center difference A.c - B.c
  logic signed [W-1:0] s1_ex_r [NUM_AXES];
  logic signed [W-1:0] s1_ey_r [NUM_AXES];
  logic signed [W:0]   s1_dx_r, s1_dy_r;
  logic signed [W:0]   s1_dx_nxt, s1_dy_nxt;

  assign s1_dx_nxt = $signed({in_a_cx[W-1], in_a_cx}) - $signed({in_b_cx[W-1], in_b_cx});
  assign s1_dy_nxt = $signed({in_a_cy[W-1], in_a_cy}) - $signed({in_b_cy[W-1], in_b_cy});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ex_r[0] <= in_a_u_x;
      s1_ey_r[0] <= in_a_u_y;
      s1_ex_r[1] <= in_a_v_x;
      s1_ey_r[1] <= in_a_v_y;
      s1_ex_r[2] <= in_b_u_x;
      s1_ey_r[2] <= in_b_u_y;
      s1_ex_r[3] <= in_b_v_x;
      s1_ey_r[3] <= in_b_v_y;
      s1_dx_r    <= s1_dx_nxt;
      s1_dy_r    <= s1_dy_nxt;
    end
  end

  // stage 2: component products, row i is the test axis
  logic signed [PW-1:0] s2_px_nxt [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] s2_py_nxt [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0] s2_cx_nxt [NUM_AXES];
  logic signed [CW-1:0] s2_cy_nxt [NUM_AXES];
  logic signed [PW-1:0] s2_px_r   [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] s2_py_r   [NUM_AXES][NUM_AXES];
  logic signed [CW-1:0] s2_cx_r   [NUM_AXES];
  logic signed [CW-1:0] s2_cy_r   [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        s2_px_nxt[i][j] = s1_ex_r[j] * s1_ex_r[i];
        s2_py_nxt[i][j] = s1_ey_r[j] * s1_ey_r[i];
      end
      s2_cx_nxt[i] = s1_dx_r * s1_ex_r[i];
      s2_cy_nxt[i] = s1_dy_r * s1_ey_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_px_r <= s2_px_nxt;
      s2_py_r <= s2_py_nxt;
      s2_cx_r <= s2_cx_nxt;
      s2_cy_r <= s2_cy_nxt;
    end
  end

  // stage 3: dot products and their magnitudes
  // edge dot magnitude never exceeds 2^(2W-1), so PW bits hold it unsigned
  logic [PW-1:0] s3_ad_nxt [NUM_AXES][NUM_AXES];
  logic [CW-1:0] s3_cd_nxt [NUM_AXES];
  logic [PW-1:0] s3_ad_r   [NUM_AXES][NUM_AXES];
  logic [CW-1:0] s3_cd_r   [NUM_AXES];

  always_comb begin
    logic signed [PW:0] edot;
    logic signed [CW:0] cdot;
    logic        [PW:0] emag;
    logic        [CW:0] cmag;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        edot = $signed({s2_px_r[i][j][PW-1], s2_px_r[i][j]})
             + $signed({s2_py_r[i][j][PW-1], s2_py_r[i][j]});
        emag = edot[PW] ? (~edot + 1'b1) : edot;
        s3_ad_nxt[i][j] = emag[PW-1:0];
      end
      cdot = $signed({s2_cx_r[i][CW-1], s2_cx_r[i]})
           + $signed({s2_cy_r[i][CW-1], s2_cy_r[i]});
      cmag = cdot[CW] ? (~cdot + 1'b1) : cdot;
      s3_cd_nxt[i] = cmag[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ad_r <= s3_ad_nxt;
      s3_cd_r <= s3_cd_nxt;
    end
  end

  // stage 4: projected extent sum and doubled center term per axis
  logic [SW-1:0] s4_s_nxt [NUM_AXES];
  logic [SW-1:0] s4_d_nxt [NUM_AXES];
  logic [SW-1:0] s4_s_r   [NUM_AXES];
  logic [SW-1:0] s4_d_r   [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s4_s_nxt[i] = {2'b00, s3_ad_r[i][0]} + {2'b00, s3_ad_r[i][1]}
                  + {2'b00, s3_ad_r[i][2]} + {2'b00, s3_ad_r[i][3]};
      s4_d_nxt[i] = {s3_cd_r[i], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_s_r <= s4_s_nxt;
      s4_d_r <= s4_d_nxt;
    end
  end

  // stage 5: any axis with center term strictly above the extent separates
  // touching boxes (equal terms) still count as overlap
  logic out_overlap_r, out_overlap_nxt;

  always_comb begin
    logic sep;
    sep = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sep = sep | (s4_d_r[i] > s4_s_r[i]);
    end
    out_overlap_nxt = !sep;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_overlap_r <= out_overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule

// File: rtl/core/obb_chk.sv
module obb_chk
  import obb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_overlap
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_overlap))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // with the output drained every cycle an input reaches the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready, LATENCY)
    && $past(out_ready, 1) && $past(out_ready, 2)
    && $past(out_ready, 3) && $past(out_ready, 4)
    && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
    && $past(rst_n, 4) && $past(rst_n, LATENCY)
    |-> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind obb_overlap_separating_axis obb_chk u_obb_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_overlap (out_overlap)
);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb
  import obb_pkg::*;
();

  localparam int W = COORD_WIDTH_DEF;
  localparam int RANDOM_PAIRS = 1500;
  // no idling on either side for this many pairs at the end
  localparam int CALM_TAIL = 200;

  typedef struct {
    logic signed [W-1:0] u_x;
    logic signed [W-1:0] u_y;
    logic signed [W-1:0] v_x;
    logic signed [W-1:0] v_y;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
  } box_t;

  typedef struct {
    box_t a;
    box_t b;
  } pair_t;

  // keeps the predicted overlap flag of every accepted box pair, oldest first
  class overlap_scoreboard;
    bit overlap_expected[$];
    int pairs_noted;
    int results_checked;
    int overlapping;
    int mismatches;

    function longint mag(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // separating axis test at full precision, all terms fit easily in 64 bits
    function bit boxes_overlap(pair_t p);
      longint ex[4];
      longint ey[4];
      longint dx, dy, span, gap;
      bit hit;
      hit = 1'b1;
      ex[0] = p.a.u_x;  ey[0] = p.a.u_y;
      ex[1] = p.a.v_x;  ey[1] = p.a.v_y;
      ex[2] = p.b.u_x;  ey[2] = p.b.u_y;
      ex[3] = p.b.v_x;  ey[3] = p.b.v_y;
      dx = longint'(p.a.cx) - longint'(p.b.cx);
      dy = longint'(p.a.cy) - longint'(p.b.cy);
      for (int i = 0; i < NUM_AXES; i++) begin
        span = 0;
        for (int j = 0; j < NUM_AXES; j++)
          span += mag(ex[j] * ex[i] + ey[j] * ey[i]);
        // half extents are folded into the doubled center term
        gap = 2 * mag(dx * ex[i] + dy * ey[i]);
        if (gap > span) hit = 1'b0;
      end
      return hit;
    endfunction

    function void note_pair(pair_t p);
      overlap_expected.insert(overlap_expected.size(), boxes_overlap(p));
      pairs_noted++;
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic got);
      bit want;
      if (overlap_expected.size() == 0) begin
        flag_mismatch($sformatf("result with no box pair waiting, overlap %b", got));
        return;
      end
      want = overlap_expected.pop_front();
      results_checked++;
      if (want) overlapping++;
      if (got !== want)
        flag_mismatch($sformatf("result %0d: overlap %b, predicted %b",
                                results_checked, got, want));
    endtask

    function int pending();
      return overlap_expected.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [W-1:0] in_a_u_x, in_a_u_y, in_a_v_x, in_a_v_y, in_a_cx, in_a_cy;
  logic signed [W-1:0] in_b_u_x, in_b_u_y, in_b_v_x, in_b_v_y, in_b_cx, in_b_cy;
  logic out_valid;
  logic out_ready;
  logic out_overlap;

  overlap_scoreboard sb;

  // idle and stall odds in percent, changed every few hundred pairs
  int idle_pct;
  int stall_pct;
  bit quiet;

  obb_overlap_separating_axis #(
    .COORD_WIDTH(W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_a_u_x   (in_a_u_x),
    .in_a_u_y   (in_a_u_y),
    .in_a_v_x   (in_a_v_x),
    .in_a_v_y   (in_a_v_y),
    .in_a_cx    (in_a_cx),
    .in_a_cy    (in_a_cy),
    .in_b_u_x   (in_b_u_x),
    .in_b_u_y   (in_b_u_y),
    .in_b_v_x   (in_b_v_x),
    .in_b_v_y   (in_b_v_y),
    .in_b_cx    (in_b_cx),
    .in_b_cy    (in_b_cy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_overlap(out_overlap)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // fields wrap to W bits like the port does
  function automatic box_t make_box(input int ux, uy, vx, vy, cx, cy);
    box_t b;
    b.u_x = W'(ux);  b.u_y = W'(uy);
    b.v_x = W'(vx);  b.v_y = W'(vy);
    b.cx  = W'(cx);  b.cy  = W'(cy);
    return b;
  endfunction

  function automatic pair_t join_boxes(input box_t a, input box_t b);
    pair_t p;
    p.a = a;
    p.b = b;
    return p;
  endfunction

  // signed value in [-lim, lim]
  function automatic int srand(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int kind, hp, hq, hr, hs, ax, ay, sgn, nudge, x0, y0, x1, y1;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      // any bit pattern at all, mostly far apart or huge boxes
      p.a = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      p.b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 7) begin
      // small skewed boxes close together, both outcomes common
      p.a = make_box(srand(1024), srand(1024), srand(1024), srand(1024),
                     srand(2048), srand(2048));
      p.b = make_box(srand(1024), srand(1024), srand(1024), srand(1024),
                     srand(2048), srand(2048));
    end else if (kind < 9) begin
      // axis-aligned boxes touching, or one lsb in or out of contact
      hp = $urandom_range(1, 4000);
      hq = $urandom_range(1, 4000);
      hr = $urandom_range(1, 4000);
      hs = $urandom_range(1, 4000);
      ax = srand(8000);
      ay = srand(8000);
      sgn = $urandom_range(0, 1) ? 1 : -1;
      nudge = int'($urandom_range(0, 2)) - 1;
      p.a = make_box(2 * hp, 0, 0, 2 * hq, ax, ay);
      if ($urandom_range(0, 1))
        p.b = make_box(2 * hr, 0, 0, -2 * hs, ax + sgn * (hp + hr) + nudge,
                       ay + srand(hq + hs));
      else
        p.b = make_box(-2 * hr, 0, 0, 2 * hs, ax + srand(hp + hr),
                       ay + sgn * (hq + hs) + nudge);
    end else begin
      // rotated rectangles with perpendicular edges
      x0 = srand(2000);  y0 = srand(2000);
      x1 = srand(2000);  y1 = srand(2000);
      p.a = make_box(x0, y0, -y0, x0, srand(3000), srand(3000));
      p.b = make_box(x1, y1, y1, -x1, srand(3000), srand(3000));
    end
    return p;
  endfunction

  // hold the pair on the port until the transfer, valid stays up for the next one
  task automatic send_pair(input pair_t p);
    int gap;
    if (!quiet && int'($urandom_range(0, 99)) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_a_u_x <= p.a.u_x;  in_a_u_y <= p.a.u_y;
    in_a_v_x <= p.a.v_x;  in_a_v_y <= p.a.v_y;
    in_a_cx  <= p.a.cx;   in_a_cy  <= p.a.cy;
    in_b_u_x <= p.b.u_x;  in_b_u_y <= p.b.u_y;
    in_b_v_x <= p.b.v_x;  in_b_v_y <= p.b.v_y;
    in_b_cx  <= p.b.cx;   in_b_cy  <= p.b.cy;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
  endtask

  // result side: check every transfer, then pick out_ready for the next edge
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_overlap);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && int'($urandom_range(0, 99)) < stall_pct) begin
        stall_left = int'($urandom_range(1, 10)) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    box_t unit;
    sb = new();
    idle_pct = 30;
    stall_pct = 30;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_a_u_x <= '0;  in_a_u_y <= '0;  in_a_v_x <= '0;
    in_a_v_y <= '0;  in_a_cx  <= '0;  in_a_cy  <= '0;
    in_b_u_x <= '0;  in_b_u_y <= '0;  in_b_v_x <= '0;
    in_b_v_y <= '0;  in_b_cx  <= '0;  in_b_cy  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // 2.0 x 2.0 axis-aligned square at the origin
    unit = make_box(512, 0, 0, 512, 0, 0);

    // every edge zero length: no axis can separate
    send_pair(join_boxes(make_box(0, 0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0, 0)));
    send_pair(join_boxes(make_box(0, 0, 0, 0, 32767, 32767),
                         make_box(0, 0, 0, 0, -32768, -32768)));
    // field extremes
    send_pair(join_boxes(make_box(32767, 32767, 32767, 32767, 32767, 32767),
                         make_box(32767, 32767, 32767, 32767, 32767, 32767)));
    send_pair(join_boxes(make_box(-32768, -32768, -32768, -32768, -32768, -32768),
                         make_box(-32768, -32768, -32768, -32768, -32768, -32768)));
    send_pair(join_boxes(make_box(32767, 32767, 32767, 32767, 32767, 32767),
                         make_box(-32768, -32768, -32768, -32768, -32768, -32768)));
    send_pair(join_boxes(make_box(32767, -32768, -32768, 32767, -32768, 32767),
                         make_box(-32768, 32767, 32767, -32768, 32767, -32768)));
    send_pair(join_boxes(make_box(1, 0, 0, 1, 32767, -32768),
                         make_box(-1, 0, 0, -1, -32768, 32767)));
    // alternating bit patterns
    send_pair(join_boxes(make_box(21845, -21846, 21845, -21846, 21845, -21846),
                         make_box(-21846, 21845, -21846, 21845, -21846, 21845)));
    // faces touching, one lsb apart, one lsb overlapping
    send_pair(join_boxes(unit, make_box(512, 0, 0, 512, 512, 0)));
    send_pair(join_boxes(unit, make_box(512, 0, 0, 512, 513, 0)));
    send_pair(join_boxes(unit, make_box(512, 0, 0, 512, 511, 0)));
    send_pair(join_boxes(unit, make_box(512, 0, 0, -512, 0, -512)));
    send_pair(join_boxes(unit, make_box(512, 0, 0, -512, 0, -513)));
    // corners touching, and just apart
    send_pair(join_boxes(unit, make_box(-512, 0, 0, 512, 512, 512)));
    send_pair(join_boxes(unit, make_box(-512, 0, 0, 512, 513, 513)));
    // a point against a square, on its face and just outside
    send_pair(join_boxes(make_box(0, 0, 0, 0, 256, 0), unit));
    send_pair(join_boxes(make_box(0, 0, 0, 0, 257, 0), unit));
    // a 45 degree box on the diagonal of the square, apart at both distances
    send_pair(join_boxes(make_box(256, 256, -256, 256, 900, 900), unit));
    send_pair(join_boxes(make_box(256, 256, -256, 256, 600, 600), unit));
    // one edge zero, the other not
    send_pair(join_boxes(make_box(512, 0, 0, 0, 0, 0), make_box(0, 512, 0, 0, 300, 0)));
    send_pair(join_boxes(make_box(512, 0, 0, 0, 0, 0), make_box(0, 512, 0, 0, 600, 0)));

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 250 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 15;
          2: idle_pct = 40;
          default: idle_pct = 70;
        endcase
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 15;
          2: stall_pct = 40;
          default: stall_pct = 70;
        endcase
      end
      if (n >= RANDOM_PAIRS - CALM_TAIL) quiet = 1'b1;
      send_pair(rand_pair());
    end
    in_valid <= 1'b0;

    // drain, then watch a little longer for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("checked %0d box pairs, %0d overlapping and %0d separated",
             sb.results_checked, sb.overlapping, sb.results_checked - sb.overlapping);
    $display("covered field extremes, zero edges, touching faces and corners, %0d random",
             RANDOM_PAIRS);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
